@@ rtl/fdrle_pkg.sv @@
// Shared constants and types for the frame difference run length encoder.
package fdrle_pkg;

   localparam int SYM_W              = 8;
   localparam int RUN_LEN_W          = 14;
   localparam int MAX_FRAME_BYTES_DEF = 8192;

   // Code points of the output stream
   localparam logic [SYM_W-1:0] SKIP_CODE    = 8'd32;
   localparam logic [SYM_W-1:0] DIGIT_OFFSET = 8'd33;
   localparam int               DIGIT_BASE   = 31;
   localparam int               DIGIT_W      = 5;

   // floor(n / 31) == (n * RECIP_MULT) >> RECIP_SHIFT for every n below 2**RUN_LEN_W
   localparam int               RECIP_W      = 16;
   localparam logic [RECIP_W-1:0] RECIP_MULT = 16'd33826;
   localparam int               RECIP_SHIFT  = 20;

   // Depth of the run command queue between front and back
   localparam int CMD_DEPTH = 4;

   // One command: flush run A (symbol plus count digits), then the one-item run B.
   typedef struct packed {
      logic [SYM_W-1:0]     a_sym;
      logic [RUN_LEN_W-1:0] a_len;
      logic                 a_vld;
      logic [SYM_W-1:0]     b_sym;
      logic                 b_vld;
      logic                 last;
   } cmd_type;

endpackage

@@ rtl/fdrle_chan_if.sv @@
// Valid/ready channel interfaces for the request and response streams.
interface fdrle_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] prev_byte;
   logic [7:0] cur_byte;
   logic       frame_end;

   modport source (output valid, output prev_byte, output cur_byte, output frame_end,
                   input ready);
   modport sink   (input valid, input prev_byte, input cur_byte, input frame_end,
                   output ready);
endinterface

interface fdrle_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] code_byte;
   logic       last_code;

   modport source (output valid, output code_byte, output last_code, input ready);
   modport sink   (input valid, input code_byte, input last_code, output ready);
endinterface

@@ rtl/fdrle_front.sv @@
// Front end: classifies each item, tracks the open run and issues flush commands.
module fdrle_front
   import fdrle_pkg::*;
#(
   parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
   input  logic         clock,
   input  logic         reset,
   fdrle_req_if.sink    req_chan,
   output cmd_type      cmd_data,
   output logic         cmd_push,
   input  logic         cmd_full
);

   localparam logic [RUN_LEN_W-1:0] RunCap = RUN_LEN_W'(MAX_FRAME_BYTES);

   logic [SYM_W-1:0]     run_symbol_ff, run_symbol_in;
   logic [RUN_LEN_W-1:0] run_length_ff, run_length_in;

   logic                 accept;
   logic [SYM_W-1:0]     sym;
   logic                 extend;
   logic [SYM_W-1:0]     open_sym;
   logic [RUN_LEN_W-1:0] open_len;
   cmd_type              cmd;

   assign req_chan.ready = !cmd_full;
   assign accept         = req_chan.valid && req_chan.ready;

   // Classify the item and decide whether it extends the open run
   assign sym    = (req_chan.cur_byte == req_chan.prev_byte) ? SKIP_CODE : req_chan.cur_byte;
   assign extend = (run_length_ff != '0) && (sym == run_symbol_ff) && (run_length_ff < RunCap);

   always_comb begin
      cmd      = '0;
      open_sym = sym;
      open_len = RUN_LEN_W'(1);
      if (extend) begin
         open_sym = run_symbol_ff;
         open_len = run_length_ff + RUN_LEN_W'(1);
      end else begin
         // close the previous run
         cmd.a_vld = (run_length_ff != '0);
         cmd.a_sym = run_symbol_ff;
         cmd.a_len = run_length_ff;
      end
      if (req_chan.frame_end) begin
         cmd.last = 1'b1;
         // flush the run still open at frame end, drop a skip tail
         if (extend) begin
            cmd.a_vld = (open_sym != SKIP_CODE);
            cmd.a_sym = open_sym;
            cmd.a_len = open_len;
         end else begin
            cmd.b_vld = (open_sym != SKIP_CODE);
            cmd.b_sym = open_sym;
         end
      end
   end

   assign cmd_data = cmd;
   assign cmd_push = accept && (cmd.a_vld || cmd.b_vld);

   // Advance the open run; frame end closes everything
   always_comb begin
      run_symbol_in = run_symbol_ff;
      run_length_in = run_length_ff;
      if (accept) begin
         if (req_chan.frame_end) begin
            run_symbol_in = '0;
            run_length_in = '0;
         end else begin
            run_symbol_in = open_sym;
            run_length_in = open_len;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_symbol_ff <= '0;
         run_length_ff <= '0;
      end else begin
         run_symbol_ff <= run_symbol_in;
         run_length_ff <= run_length_in;
      end
   end

endmodule

@@ rtl/fdrle_cmd_queue.sv @@
// Small register queue of flush commands between front and back.
module fdrle_cmd_queue
   import fdrle_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   output cmd_type head,
   output logic    head_valid,
   input  logic    pop
);

   localparam int PtrW = $clog2(CMD_DEPTH);
   localparam int CntW = $clog2(CMD_DEPTH + 1);

   cmd_type          entry_ff [CMD_DEPTH];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;

   assign full       = (count_ff == CntW'(CMD_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = entry_ff[rd_ptr_ff];

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(CMD_DEPTH - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(CMD_DEPTH - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CntW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store pushed command
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ rtl/fdrle_back.sv @@
// Back end: expands flush commands into symbol and count digit code bytes.
module fdrle_back
   import fdrle_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     head,
   input  logic        head_valid,
   output logic        pop,
   fdrle_rsp_if.source rsp_chan
);

   localparam int ProdW = RUN_LEN_W + RECIP_W;

   // Work registers of the command in progress
   logic                 a_pend_ff, a_pend_in;
   logic                 dig_pend_ff, dig_pend_in;
   logic                 b_pend_ff, b_pend_in;
   logic [SYM_W-1:0]     a_sym_ff, a_sym_in;
   logic [SYM_W-1:0]     b_sym_ff, b_sym_in;
   logic [RUN_LEN_W-1:0] rest_ff, rest_in;
   logic                 last_ff, last_in;

   // Output register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [SYM_W-1:0]     rsp_code_ff, rsp_code_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 load_ok;
   logic                 busy;
   logic                 emit;
   logic                 cmd_done;
   logic [SYM_W-1:0]     code;
   logic [ProdW-1:0]     prod;
   logic [RUN_LEN_W-1:0] quot;
   logic [RUN_LEN_W-1:0] times31;
   logic [RUN_LEN_W-1:0] rem_full;
   logic [DIGIT_W-1:0]   rem;
   logic [SYM_W-1:0]     digit_code;

   assign load_ok = !rsp_valid_ff || rsp_chan.ready;
   assign busy    = a_pend_ff || dig_pend_ff || b_pend_ff;

   // Split off the low base-31 digit by reciprocal multiply
   assign prod       = ProdW'(rest_ff) * ProdW'(RECIP_MULT);
   assign quot       = RUN_LEN_W'(prod >> RECIP_SHIFT);
   assign times31    = RUN_LEN_W'({quot, 5'b0} - {5'b0, quot});
   assign rem_full   = rest_ff - times31;
   assign rem        = rem_full[DIGIT_W-1:0];
   assign digit_code = DIGIT_OFFSET + SYM_W'(rem);

   // One code byte a cycle unless stalled; next command when idle or done
   always_comb begin
      a_pend_in   = a_pend_ff;
      dig_pend_in = dig_pend_ff;
      b_pend_in   = b_pend_ff;
      a_sym_in    = a_sym_ff;
      b_sym_in    = b_sym_ff;
      rest_in     = rest_ff;
      last_in     = last_ff;
      emit        = 1'b0;
      code        = b_sym_ff;
      if (load_ok && busy) begin
         emit = 1'b1;
         if (a_pend_ff) begin
            code        = a_sym_ff;
            a_pend_in   = 1'b0;
            dig_pend_in = (rest_ff > RUN_LEN_W'(1));
         end else if (dig_pend_ff) begin
            code        = digit_code;
            rest_in     = quot;
            dig_pend_in = (quot != '0);
         end else begin
            code      = b_sym_ff;
            b_pend_in = 1'b0;
         end
      end
      cmd_done = emit && !(a_pend_in || dig_pend_in || b_pend_in);
      pop      = head_valid && (!busy || cmd_done);
      if (pop) begin
         a_pend_in   = head.a_vld;
         dig_pend_in = 1'b0;
         b_pend_in   = head.b_vld;
         a_sym_in    = head.a_sym;
         b_sym_in    = head.b_sym;
         rest_in     = head.a_len;
         last_in     = head.last;
      end
   end

   // Load the output register when it is free or being taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_code_in  = rsp_code_ff;
      rsp_last_in  = rsp_last_ff;
      if (load_ok) begin
         rsp_valid_in = emit;
         rsp_code_in  = code;
         rsp_last_in  = cmd_done && last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_pend_ff    <= 1'b0;
         dig_pend_ff  <= 1'b0;
         b_pend_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         a_pend_ff    <= a_pend_in;
         dig_pend_ff  <= dig_pend_in;
         b_pend_ff    <= b_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_sym_ff    <= a_sym_in;
      b_sym_ff    <= b_sym_in;
      rest_ff     <= rest_in;
      last_ff     <= last_in;
      rsp_code_ff <= rsp_code_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.code_byte = rsp_code_ff;
   assign rsp_chan.last_code = rsp_last_ff;

endmodule

@@ rtl/frame_diff_run_length_encoder.sv @@
// Top level of the frame difference run length encoder.
//
//   channel   dir  modport  payload
//   req_chan  in   sink     prev_byte[7:0], cur_byte[7:0], frame_end
//   rsp_chan  out  source   code_byte[7:0], last_code
//
// Input takes one item per cycle; req_chan.ready drops only while the four-entry
// command queue is full. Code bytes leave the back end through its output register,
// one per cycle while rsp_chan is ready; a run of length n > 1 yields its symbol and
// then the base-31 digits of n, and the queue absorbs these bursts.
// Reset clears the open run, the queue and the output register; no clearing pass.
// A stall on rsp_chan holds the output register and fills the queue.
module frame_diff_run_length_encoder
   import fdrle_pkg::*;
#(
   parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   fdrle_req_if.sink   req_chan,
   fdrle_rsp_if.source rsp_chan
);

   cmd_type cmd_data;
   logic    cmd_push;
   logic    cmd_full;
   cmd_type cmd_head;
   logic    cmd_head_valid;
   logic    cmd_pop;

   fdrle_front #(
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .cmd_data (cmd_data),
      .cmd_push (cmd_push),
      .cmd_full (cmd_full)
   );

   fdrle_cmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (cmd_push),
      .push_data  (cmd_data),
      .full       (cmd_full),
      .head       (cmd_head),
      .head_valid (cmd_head_valid),
      .pop        (cmd_pop)
   );

   fdrle_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (cmd_head),
      .head_valid (cmd_head_valid),
      .pop        (cmd_pop),
      .rsp_chan   (rsp_chan)
   );

endmodule

@@ rtl/fdrle_checker.sv @@
// Port-level checks for the frame difference run length encoder, with its bind.
module fdrle_checker
   import fdrle_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_code_byte,
   input logic       rsp_last_code
);

   // Hold a stalled response
   ast_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_code_byte)
                                  && $stable(rsp_last_code))
      else $error("stalled response changed");

   // Leave reset with nothing to deliver
   ast_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // Never close a frame on a skip code
   ast_last_not_skip: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_code |-> rsp_code_byte != SKIP_CODE)
      else $error("frame closed on skip code");

   // After a closing skip code, never close again at once on a count digit
   ast_last_once: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last_code |=>
         !(rsp_valid && rsp_last_code && rsp_code_byte >= DIGIT_OFFSET
           && rsp_code_byte < DIGIT_OFFSET + 8'd31 && $past(rsp_code_byte) == SKIP_CODE))
      else $error("count digit closing a frame after a skip-only frame");

endmodule

bind frame_diff_run_length_encoder fdrle_checker u_fdrle_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_code_byte (rsp_chan.code_byte),
   .rsp_last_code (rsp_chan.last_code)
);
